FILE: rtl/core/blank_skipping_multi_word_matcher_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the blank-skipping multi-word matcher
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLANK_SKIPPING_MULTI_WORD_MATCHER_UNIT_DEFINES_SVH
`define BLANK_SKIPPING_MULTI_WORD_MATCHER_UNIT_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define BSMWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define BSMWM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/bsmwm_pkg.sv
// ----------------------------------------------------------------------------
// bsmwm_pkg
// Types, blank codes and the built-in word list of the matcher.
// ----------------------------------------------------------------------------
package bsmwm_pkg;

    localparam logic [7:0] BLANK_SPACE   = 8'h20;
    localparam logic [7:0] BLANK_TAB     = 8'h09;
    localparam logic [7:0] BLANK_NEWLINE = 8'h0A;

    localparam int BUILTIN_COUNT = 7;
    localparam int BUILTIN_MAX   = 12;

    localparam logic [7:0] BUILTIN_WORDS [0:BUILTIN_COUNT-1][0:BUILTIN_MAX-1] = '{
        '{8'h64, 8'h69, 8'h61, 8'h6F, 8'h79, 8'h75, 8'h64, 8'h61, 8'h6F,
          8'h00, 8'h00, 8'h00},
        '{8'h6A, 8'h69, 8'h61, 8'h6E, 8'h67, 8'h65, 8'h6C, 8'h69, 8'h65,
          8'h64, 8'h61, 8'h6F},
        '{8'hE9, 8'h92, 8'h93, 8'hE9, 8'hB1, 8'hBC, 8'hE5, 8'hB2, 8'h9B,
          8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'hB0, 8'h96, 8'hE9, 8'h9A, 8'h94, 8'hE5, 8'h88, 8'h97,
          8'hE5, 8'hB2, 8'h9B},
        '{8'hE5, 8'hB0, 8'h96, 8'hE9, 8'h98, 8'h81, 8'hE5, 8'h88, 8'h97,
          8'hE5, 8'hB2, 8'h9B},
        '{8'hE9, 8'h97, 8'hB4, 8'hE9, 8'h9A, 8'h94, 8'hE5, 8'h88, 8'h97,
          8'hE5, 8'hB2, 8'h9B},
        '{8'hE9, 8'h97, 8'hB4, 8'hE9, 8'h98, 8'h81, 8'hE5, 8'h88, 8'h97,
          8'hE5, 8'hB2, 8'h9B}
    };

    localparam int BUILTIN_LENGTHS [0:BUILTIN_COUNT-1] = '{9, 12, 9, 12, 12, 12, 12};

    // control handed from the top level to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } bsmwm_ctl_t;

    // byte k of word w, zero outside the list
    function automatic logic [7:0] builtin_byte(input int w, input int k);
        logic [7:0] r;
        r = '0;
        if (w >= 0 && w < BUILTIN_COUNT && k >= 0 && k < BUILTIN_MAX)
        begin
            r = BUILTIN_WORDS[w][k];
        end
        return r;
    endfunction

    // loaded length of word w; words that do not fit the window are not loaded
    function automatic int builtin_len(input int w, input int max_len);
        int r;
        r = 0;
        if (w >= 0 && w < BUILTIN_COUNT)
        begin
            if (BUILTIN_LENGTHS[w] <= max_len && BUILTIN_LENGTHS[w] <= BUILTIN_MAX)
            begin
                r = BUILTIN_LENGTHS[w];
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/bsmwm_cell.sv
// ----------------------------------------------------------------------------
// bsmwm_cell
// One position of the match chain: keeps, per word, whether the newest
// bytes match that word's prefix ending at this position.
// ----------------------------------------------------------------------------
module bsmwm_cell
    import bsmwm_pkg::*;
#(
    parameter int WORD_COUNT   = 8,
    parameter int MAX_WORD_LEN = 16,
    parameter int CELL_IDX     = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsmwm_ctl_t            ctl,
    input  logic [7:0]            text_byte,
    input  logic [WORD_COUNT-1:0] prefix_in,
    output logic [WORD_COUNT-1:0] prefix_out,
    output logic                  word_hit
);

    logic [WORD_COUNT-1:0] prefix_reg;
    logic [WORD_COUNT-1:0] prefix_next;
    logic [WORD_COUNT-1:0] cand;
    logic [WORD_COUNT-1:0] ends_here;
    logic [WORD_COUNT-1:0] keep;

    always_comb
    begin
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            cand[w]      = prefix_in[w]
                           && (builtin_len(w, MAX_WORD_LEN) > CELL_IDX)
                           && (text_byte == builtin_byte(w, CELL_IDX));
            ends_here[w] = (builtin_len(w, MAX_WORD_LEN) == CELL_IDX + 1);
            // only prefixes that can still grow move down the chain
            keep[w]      = (builtin_len(w, MAX_WORD_LEN) > CELL_IDX + 1);
        end
    end

    always_comb
    begin
        if (ctl.clear)
        begin
            prefix_next = '0;
        end
        else if (ctl.shift)
        begin
            prefix_next = cand & keep;
        end
        else
        begin
            prefix_next = prefix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
        end
        else
        begin
            prefix_reg <= prefix_next;
        end
    end

    assign prefix_out = prefix_reg;
    assign word_hit   = ctl.shift && |(cand & ends_here);

endmodule

FILE: rtl/core/blank_skipping_multi_word_matcher_unit.sv
// ----------------------------------------------------------------------------
// blank_skipping_multi_word_matcher_unit
// Streams text bytes, drops blanks and flags texts holding a listed word.
//
//   channel | signals                         | moves
//   --------+---------------------------------+------------------------------
//   input   | in_valid in_ready               | text_byte, last_byte
//   output  | out_valid out_ready             | is_dirty, one per text
//
// one byte per cycle while in_ready is high; each cell compares the byte
// with one column of the word list and hands its prefix flags to the next
// cell, so a word is found in the cycle its last byte arrives
// the result is registered and appears the cycle after the last byte
// reset clears the chain, the hit flag and the output register
// while a result waits, bytes that are not the last keep flowing
// ----------------------------------------------------------------------------
`include "blank_skipping_multi_word_matcher_unit_defines.svh"

module blank_skipping_multi_word_matcher_unit
    import bsmwm_pkg::*;
#(
    parameter int MAX_WORD_LEN = 16,
    parameter int WORD_COUNT   = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_dirty
);

    logic                  in_accept;
    logic                  nonblank;
    bsmwm_ctl_t            ctl;
    logic [WORD_COUNT-1:0] chain [0:MAX_WORD_LEN];
    logic [MAX_WORD_LEN-1:0] cell_hit;
    logic                  any_hit;

    logic hit_reg;
    logic hit_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic is_dirty_reg;
    logic is_dirty_next;

    // only the last byte needs the output slot
    assign in_ready  = !out_valid_reg || out_ready || !last_byte;
    assign in_accept = in_valid && in_ready;
    assign nonblank  = (text_byte != BLANK_SPACE) && (text_byte != BLANK_TAB)
                       && (text_byte != BLANK_NEWLINE);

    assign ctl.shift = in_accept && nonblank;
    assign ctl.clear = in_accept && last_byte;

    assign chain[0] = '1;

    for (genvar k = 0; k < MAX_WORD_LEN; k++)
    begin : g_cell
        bsmwm_cell #(
            .WORD_COUNT   (WORD_COUNT),
            .MAX_WORD_LEN (MAX_WORD_LEN),
            .CELL_IDX     (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .text_byte  (text_byte),
            .prefix_in  (chain[k]),
            .prefix_out (chain[k+1]),
            .word_hit   (cell_hit[k])
        );
    end

    assign any_hit = |cell_hit;

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (any_hit)
        begin
            hit_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (ctl.clear)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        is_dirty_next = is_dirty_reg;
        if (ctl.clear)
        begin
            is_dirty_next = hit_reg || any_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            is_dirty_reg  <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            is_dirty_reg  <= is_dirty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_dirty  = is_dirty_reg;

    `BSMWM_ASSERT(a_tail_cell_empty, chain[MAX_WORD_LEN] == '0, "prefix left the chain end")
    `BSMWM_ASSERT_NEXT(a_result_after_last, ctl.clear, out_valid_reg, "no result after last byte")
    `BSMWM_ASSERT_NEXT(a_hit_cleared, ctl.clear, !hit_reg, "hit flag survived end of text")

endmodule

FILE: tb/blank_skipping_multi_word_matcher_unit_test.sv
// ----------------------------------------------------------------------------
// blank_skipping_multi_word_matcher_unit_test
// Feeds texts byte by byte through the matcher and checks every verdict
// against a local model of the blank-dropping window and the word list.
// ----------------------------------------------------------------------------
module blank_skipping_multi_word_matcher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsmwm_pkg::*;

    localparam int WINDOW_LEN = 16;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       is_dirty;

    // model state
    logic [7:0] text_window [WINDOW_LEN] = '{default: 8'h00};
    logic       word_seen = 1'b0;
    logic       expected_verdicts [$];

    int error_count = 0;
    int bytes_sent  = 0;

    // sender and receiver idling knobs
    int burst_left = 0;
    int gap_max    = 0;
    int stall_pct  = 0;
    int stall_max  = 0;
    int stall_left = 0;

    logic verdict_want;

    blank_skipping_multi_word_matcher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_dirty  (is_dirty)
    );

    always #5 clk = ~clk;

    function automatic void advance_matcher(input logic [7:0] b, input logic fin);
        int   len;
        logic hit_now;
        if (b != BLANK_SPACE && b != BLANK_TAB && b != BLANK_NEWLINE)
        begin
            for (int i = WINDOW_LEN - 1; i > 0; i--)
            begin
                text_window[i] = text_window[i - 1];
            end
            text_window[0] = b;
            for (int w = 0; w < BUILTIN_COUNT; w++)
            begin
                len = BUILTIN_LENGTHS[w];
                if (len > 0 && len <= WINDOW_LEN)
                begin
                    hit_now = 1'b1;
                    // first word byte sits deepest in the window
                    for (int j = 0; j < len; j++)
                    begin
                        if (BUILTIN_WORDS[w][j] != text_window[len - 1 - j])
                        begin
                            hit_now = 1'b0;
                        end
                    end
                    if (hit_now)
                    begin
                        word_seen = 1'b1;
                    end
                end
            end
        end
        if (fin)
        begin
            expected_verdicts.push_back(word_seen);
            text_window = '{default: 8'h00};
            word_seen = 1'b0;
        end
    endfunction

    task automatic note_failure(input string what, input logic want, input logic got);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%0t: %s: expected is_dirty=%b, got %b", $realtime, what, want, got);
        end
    endtask

    // called and returning at a falling edge; valid stays up within a burst and may drop between bursts
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid  <= 1'b1;
        text_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        advance_matcher(b, fin);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input logic [7:0] text_q [$]);
        for (int i = 0; i < text_q.size(); i++)
        begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
    endtask

    function automatic logic [7:0] pick_blank();
        logic [7:0] r;
        case ($urandom_range(0, 2))
            0:       r = BLANK_SPACE;
            1:       r = BLANK_TAB;
            default: r = BLANK_NEWLINE;
        endcase
        return r;
    endfunction

    // bytes first .. first+count-1 of word w, blanks sprinkled in between
    task automatic add_word(inout logic [7:0] text_q [$], input int w, input int first,
                            input int count, input int blank_pct);
        for (int k = first; k < first + count && k < BUILTIN_LENGTHS[w]; k++)
        begin
            if (k > first && $urandom_range(0, 99) < blank_pct)
            begin
                text_q.push_back(pick_blank());
            end
            text_q.push_back(BUILTIN_WORDS[w][k]);
        end
    endtask

    // filler leaning toward word bytes so near misses are common
    function automatic logic [7:0] pick_filler();
        int sel;
        int w;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            w = $urandom_range(0, BUILTIN_COUNT - 1);
            return BUILTIN_WORDS[w][$urandom_range(0, BUILTIN_LENGTHS[w] - 1)];
        end
        else if (sel < 55)
        begin
            return pick_blank();
        end
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic run_random_texts(input int target);
        int          start;
        int          kind;
        int          w;
        int          n;
        logic [7:0]  text_q [$];
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            text_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
                repeat (n) text_q.push_back(pick_filler());
                w = $urandom_range(0, BUILTIN_COUNT - 1);
                n = ($urandom_range(0, 99) < 15) ? $urandom_range(1, BUILTIN_LENGTHS[w] - 1)
                                                 : BUILTIN_LENGTHS[w];
                add_word(text_q, w, 0, n, $urandom_range(0, 30));
                if ($urandom_range(0, 99) < 20)
                begin
                    // corrupt one byte, most of the time breaking the match
                    text_q[$urandom_range(text_q.size() - n, text_q.size() - 1)] =
                        8'($urandom_range(1, 255));
                end
                if ($urandom_range(0, 99) < 20)
                begin
                    w = $urandom_range(0, BUILTIN_COUNT - 1);
                    add_word(text_q, w, 0, BUILTIN_LENGTHS[w], 10);
                end
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                repeat (n) text_q.push_back(pick_filler());
            end
            else if (kind < 80)
            begin
                // a partial word running straight into another word, started at byte 0, 1 or 2
                w = $urandom_range(0, BUILTIN_COUNT - 1);
                add_word(text_q, w, 0, $urandom_range(1, BUILTIN_LENGTHS[w] - 1), 10);
                w = $urandom_range(0, BUILTIN_COUNT - 1);
                add_word(text_q, w, $urandom_range(0, 2), BUILTIN_LENGTHS[w], 10);
            end
            else
            begin
                repeat ($urandom_range(1, 24)) text_q.push_back(pick_filler());
            end
            if (text_q.size() == 0)
            begin
                text_q.push_back(pick_filler());
            end
            send_text(text_q);
        end
    endtask

    task automatic test_directed_cases();
        logic [7:0] text_q [$];
        gap_max   = 0;
        stall_pct = 0;
        // byte extremes, no word
        text_q = '{8'hFF, 8'h01};
        send_text(text_q);
        // text that is one blank only
        text_q = '{BLANK_SPACE};
        send_text(text_q);
        // multi-byte word with a newline inside, completed on the final byte
        text_q.delete();
        add_word(text_q, 2, 0, 4, 0);
        text_q.push_back(BLANK_NEWLINE);
        add_word(text_q, 2, 4, 5, 0);
        send_text(text_q);
        // zero byte, final byte a tab
        text_q = '{8'h00, BLANK_TAB};
        send_text(text_q);
        // word split across two texts must not match
        text_q.delete();
        add_word(text_q, 0, 0, 5, 0);
        send_text(text_q);
        text_q.delete();
        add_word(text_q, 0, 5, 4, 0);
        send_text(text_q);
    endtask

    task automatic test_full_rate_stream();
        gap_max   = 0;
        stall_pct = 0;
        run_random_texts(400);
    endtask

    task automatic test_bursty_traffic();
        gap_max   = 6;
        stall_pct = 30;
        stall_max = 6;
        run_random_texts(1000);
    endtask

    task automatic test_receiver_backpressure();
        gap_max   = 2;
        stall_pct = 70;
        stall_max = 20;
        run_random_texts(600);
    endtask

    // receiver stall pattern: runs of not-ready of random length
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, stall_max);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                note_failure("transaction with no verdict pending", 1'bx, is_dirty);
            end
            else
            begin
                verdict_want = expected_verdicts.pop_front();
                if (is_dirty !== verdict_want)
                begin
                    note_failure("verdict mismatch", verdict_want, is_dirty);
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_full_rate_stream();
        test_bursty_traffic();
        test_receiver_backpressure();
        in_valid <= 1'b0;
        wait (expected_verdicts.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
